[src/dqms_pkg.sv]
// ----------------------------------------------------------------------------
// dqms_pkg: shared types and constants
// kind codes, status codes, sequencer states for the deque with sort
// ----------------------------------------------------------------------------
package dqms_pkg;

  localparam int DEPTH_DEF      = 16;
  localparam int DATA_WIDTH_DEF = 32;

  localparam logic [2:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [2:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [2:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [2:0] KIND_POP_BACK   = 3'd3;
  localparam logic [2:0] KIND_PEEK_FRONT = 3'd4;
  localparam logic [2:0] KIND_PEEK_BACK  = 3'd5;
  localparam logic [2:0] KIND_SORT       = 3'd6;
  localparam logic [2:0] KIND_CLEAR      = 3'd7;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_EMPTY = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  localparam logic [1:0] REG_SORT_DESC = 2'd0;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,      // memory read in flight
    ST_RESP,    // read data back, build word
    ST_CPRD,    // copy store to scratch: read
    ST_CPWR,    // copy: write
    ST_MSET,    // set up one merge of two runs
    ST_MRD,     // read both run heads
    ST_MCMP,    // compare and write one element
    ST_BKRD,    // copy scratch back to store: read
    ST_BKWR,    // copy back: write
    ST_OUT      // word waiting at output
  } dqms_state_t;

endpackage

[src/dqms_cmp.sv]
// ----------------------------------------------------------------------------
// dqms_cmp: shared merge comparator
// decides whether the earlier run's head goes first
// ----------------------------------------------------------------------------
module dqms_cmp #(
  parameter int DATA_WIDTH = dqms_pkg::DATA_WIDTH_DEF
) (
  input  logic [DATA_WIDTH-1:0] a,
  input  logic [DATA_WIDTH-1:0] b,
  input  logic                  descending,
  output logic                  a_first
);
  // strict order, ties go to the later run
  assign a_first = descending ? (a > b) : (a < b);
endmodule

[src/deque_with_merge_sort.sv]
// ----------------------------------------------------------------------------
// deque_with_merge_sort: bounded deque with bottom-up merge sort
// circular store, two work buffers and a sequencer sharing one comparator
// ----------------------------------------------------------------------------
// usage:
//   in_tdata carries the element (value), in_tuser the request kind.
//   each accepted word gives exactly one result word: out_tdata holds
//   data [31:0], status [33:32], count [38:34].
//   push, clear and pop/peek on an empty store: out_tvalid in the cycle after
//   accept; pop/peek pass ST_RD (address the synchronous store), ST_RESP (data
//   back), then the result register. one word is in flight at a time, so
//   in_tready is low until the result is taken; no push, pop or peek is
//   accepted before the previous word's result has left.
//   sort copies the store to buf0 (read, then write each element), then per
//   pass and per pair of runs does a setup and a closing check, and for each
//   element merged reads both heads, compares in the shared comparator and
//   writes, then copies the result back to the store from slot zero.
//   sort_descending lives at cfg address 0.
//   reset clears head, count, sequencer and the register; the store itself
//   is undefined until written and needs no clearing pass.
//   a stalled receiver holds the result word; no new input is taken until
//   it leaves.
// ----------------------------------------------------------------------------
module deque_with_merge_sort #(
  parameter int DEPTH      = dqms_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = dqms_pkg::DATA_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,    // value [31:0]
  input  logic [2:0]  in_tuser,    // kind [2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // data [31:0], status [33:32], count [38:34]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import dqms_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int OW = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
  localparam int DW = DATA_WIDTH;

  // memories
  logic [DW-1:0] store_m [DEPTH];
  logic [DW-1:0] buf0_m  [DEPTH];
  logic [DW-1:0] buf1_m  [DEPTH];

  dqms_state_t   state_r, state_nxt;
  logic [AW-1:0] head_r, head_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          desc_r;
  logic [2:0]    kind_r, kind_nxt;
  logic [DW-1:0] val_r, val_nxt;
  logic [31:0]   data_r, data_nxt;
  logic [1:0]    stat_r, stat_nxt;
  logic          src_sel_r, src_sel_nxt; // 0: buf0 is source
  logic [CW-1:0] i_r, i_nxt;             // copy index
  logic [CW:0]   w_r, w_nxt;             // run width
  logic [CW:0]   a_r, a_nxt, b_r, b_nxt, mid_r, mid_nxt, end_r, end_nxt;
  logic [CW:0]   start_r, start_nxt, k_r, k_nxt;

  // store port
  logic          st_we;
  logic [AW-1:0] st_wa, st_ra;
  logic [DW-1:0] st_wd, st_rd_r;
  // buffer ports: one write, two reads on source
  logic          bf_we;
  logic          bf_wsel;
  logic [AW-1:0] bf_wa, bf_ra0, bf_ra1;
  logic [DW-1:0] bf_wd;
  logic [DW-1:0] b0_rd0_r, b0_rd1_r, b1_rd0_r, b1_rd1_r;
  logic [DW-1:0] src0, src1;
  logic          a_first;

  always_ff @(posedge clk) begin
    if (st_we) store_m[st_wa] <= st_wd;
    st_rd_r <= store_m[st_ra];
    if (bf_we && !bf_wsel) buf0_m[bf_wa] <= bf_wd;
    if (bf_we && bf_wsel)  buf1_m[bf_wa] <= bf_wd;
    b0_rd0_r <= buf0_m[bf_ra0];
    b0_rd1_r <= buf0_m[bf_ra1];
    b1_rd0_r <= buf1_m[bf_ra0];
    b1_rd1_r <= buf1_m[bf_ra1];
  end

  assign src0 = src_sel_r ? b1_rd0_r : b0_rd0_r;
  assign src1 = src_sel_r ? b1_rd1_r : b0_rd1_r;

  dqms_cmp #(.DATA_WIDTH(DW)) u_cmp (
    .a(src0), .b(src1), .descending(desc_r), .a_first(a_first)
  );

  // slot of head + offset, wrapped once
  function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] off);
    logic [CW:0] s;
    s = {{(CW+1-AW){1'b0}}, h} + {1'b0, off};
    if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = (state_r == ST_OUT);
  assign out_tdata  = {1'b0, 5'(cnt_r), stat_r, data_r};

  // config port
  assign cfg_pready = 1'b1;
  assign cfg_prdata = {31'd0, desc_r};
  always_ff @(posedge clk) begin
    if (!rst_n) desc_r <= 1'b0;
    else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
             && cfg_paddr == REG_SORT_DESC)
      desc_r <= cfg_pwdata[0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      head_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      cnt_r   <= cnt_nxt;
    end
    kind_r <= kind_nxt; val_r <= val_nxt; data_r <= data_nxt; stat_r <= stat_nxt;
    src_sel_r <= src_sel_nxt; i_r <= i_nxt; w_r <= w_nxt;
    a_r <= a_nxt; b_r <= b_nxt; mid_r <= mid_nxt; end_r <= end_nxt;
    start_r <= start_nxt; k_r <= k_nxt;
  end

  logic [CW:0]   n_ext, s_mid, s_end;
  logic [AW-1:0] head_dec;
  assign n_ext = {1'b0, cnt_r};
  // slot in front of the head, wrapping below zero
  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - AW'(1);

  always_comb begin
    state_nxt = state_r; head_nxt = head_r; cnt_nxt = cnt_r;
    kind_nxt = kind_r; val_nxt = val_r; data_nxt = data_r; stat_nxt = stat_r;
    src_sel_nxt = src_sel_r; i_nxt = i_r; w_nxt = w_r;
    a_nxt = a_r; b_nxt = b_r; mid_nxt = mid_r; end_nxt = end_r;
    start_nxt = start_r; k_nxt = k_r;
    st_we = 1'b0; st_wa = '0; st_wd = val_r; st_ra = head_r;
    bf_we = 1'b0; bf_wsel = 1'b0; bf_wa = '0; bf_wd = st_rd_r;
    bf_ra0 = a_r[AW-1:0]; bf_ra1 = b_r[AW-1:0];
    s_mid = start_r + w_r; s_end = start_r + (w_r << 1);
    if (s_mid > n_ext) s_mid = n_ext;
    if (s_end > n_ext) s_end = n_ext;
    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          kind_nxt = in_tuser;
          val_nxt  = DW'(in_tdata);
          data_nxt = '0;
          stat_nxt = STAT_OK;
          state_nxt = ST_RESP;
          case (in_tuser)
            KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
              if (cnt_r >= CW'(DEPTH)) stat_nxt = STAT_FULL;
              state_nxt = ST_OUT;
              if (cnt_r < CW'(DEPTH)) begin
                st_we = 1'b1;
                st_wd = DW'(in_tdata);
                if (in_tuser == KIND_PUSH_FRONT) begin
                  head_nxt = head_dec;
                  st_wa = head_dec;
                end else begin
                  st_wa = slot(head_r, cnt_r);
                end
                cnt_nxt = cnt_r + CW'(1);
              end
            end
            KIND_POP_FRONT, KIND_PEEK_FRONT, KIND_POP_BACK, KIND_PEEK_BACK: begin
              if (cnt_r == '0) begin
                stat_nxt = STAT_EMPTY;
                state_nxt = ST_OUT;
              end else begin
                state_nxt = ST_RD;
              end
            end
            KIND_SORT: begin
              i_nxt = '0; src_sel_nxt = 1'b0;
              state_nxt = ST_CPRD;
            end
            default: begin
              cnt_nxt = '0; head_nxt = '0; state_nxt = ST_OUT;
            end
          endcase
        end
      end
      ST_RD: begin
        // address the element to be seen or removed
        st_ra = (kind_r == KIND_POP_FRONT || kind_r == KIND_PEEK_FRONT)
                ? head_r : slot(head_r, cnt_r - CW'(1));
        state_nxt = ST_RESP;
      end
      ST_RESP: begin
        data_nxt = 32'(st_rd_r[OW-1:0]);
        state_nxt = ST_OUT;
        if (kind_r == KIND_POP_FRONT) begin
          head_nxt = slot(head_r, CW'(1));
          cnt_nxt = cnt_r - CW'(1);
        end else if (kind_r == KIND_POP_BACK) begin
          cnt_nxt = cnt_r - CW'(1);
        end
      end
      ST_CPRD: begin
        if (i_r >= cnt_r) begin
          w_nxt = (CW+1)'(1);
          start_nxt = '0;
          state_nxt = (cnt_r > CW'(1)) ? ST_MSET : ST_BKRD;
          i_nxt = '0;
        end else begin
          st_ra = slot(head_r, i_r);
          state_nxt = ST_CPWR;
        end
      end
      ST_CPWR: begin
        bf_we = 1'b1; bf_wsel = 1'b0; bf_wa = i_r[AW-1:0]; bf_wd = st_rd_r;
        i_nxt = i_r + CW'(1);
        state_nxt = ST_CPRD;
      end
      ST_MSET: begin
        if (start_r >= n_ext) begin
          // pass done: swap buffers
          src_sel_nxt = ~src_sel_r;
          w_nxt = w_r << 1;
          start_nxt = '0;
          if ((w_r << 1) >= n_ext) begin
            i_nxt = '0; state_nxt = ST_BKRD;
          end
        end else begin
          a_nxt = start_r; b_nxt = s_mid; mid_nxt = s_mid; end_nxt = s_end;
          k_nxt = start_r;
          state_nxt = ST_MRD;
        end
      end
      ST_MRD: begin
        if (a_r >= mid_r && b_r >= end_r) begin
          start_nxt = end_r;
          state_nxt = ST_MSET;
        end else begin
          state_nxt = ST_MCMP; // reads on a_r, b_r issue now
        end
      end
      ST_MCMP: begin
        bf_we = 1'b1; bf_wsel = ~src_sel_r; bf_wa = k_r[AW-1:0];
        k_nxt = k_r + (CW+1)'(1);
        if (a_r < mid_r && (b_r >= end_r || a_first)) begin
          bf_wd = src0; a_nxt = a_r + (CW+1)'(1);
        end else begin
          bf_wd = src1; b_nxt = b_r + (CW+1)'(1);
        end
        state_nxt = ST_MRD;
      end
      ST_BKRD: begin
        if (i_r >= cnt_r) begin
          head_nxt = '0; state_nxt = ST_OUT;
        end else begin
          bf_ra0 = i_r[AW-1:0];
          state_nxt = ST_BKWR;
        end
      end
      ST_BKWR: begin
        st_we = 1'b1; st_wa = i_r[AW-1:0]; st_wd = src0;
        i_nxt = i_r + CW'(1);
        state_nxt = ST_BKRD;
      end
      ST_OUT: if (out_tready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // count never exceeds the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("count above depth");
  // result word holds while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped under stall");
  // no input taken while a result waits
  a_one_flight: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input accepted with result pending");
  // sort leaves front at slot zero
  a_sort_head: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_BKRD && i_r >= cnt_r) |=> head_r == '0)
    else $error("head not reset after sort");

endmodule

[tb/dqms_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dqms_checker: result checker for the deque with merge sort
// mirrors the deque and its sort, compares every result word in order
// ----------------------------------------------------------------------------
module dqms_checker
  import dqms_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,    // value [31:0]
  input  logic [2:0]  in_tuser,    // kind [2:0]
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,   // data [31:0], status [33:32], count [38:34]
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [1:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [4:0]  count;
    logic [1:0]  status;
    logic [31:0] data;
  } dq_result_t;

  // expected words, kept as a small ring
  dq_result_t  exp_m[16];
  logic [3:0]  exp_wr, exp_rd;
  int          exp_cnt;
  logic [31:0] store_m[16];
  logic [3:0]  head_m;
  logic [4:0]  count_m;
  logic        desc_m;

  assign pending = exp_cnt;

  function automatic logic [3:0] slot(input int off);
    return 4'((head_m + off) % 16);
  endfunction

  // bottom-up merge, later run wins ties
  task automatic sort_model();
    logic [31:0] src[16];
    logic [31:0] dst[16];
    int n, w, s, m, e, a, b, k;
    n = count_m;
    for (int i = 0; i < n; i++) src[i] = store_m[slot(i)];
    for (w = 1; w < n; w *= 2) begin
      for (s = 0; s < n; s += 2 * w) begin
        m = (s + w > n) ? n : s + w;
        e = (s + 2 * w > n) ? n : s + 2 * w;
        a = s; b = m; k = s;
        while (a < m && b < e) begin
          if (desc_m ? (src[a] > src[b]) : (src[a] < src[b])) dst[k++] = src[a++];
          else dst[k++] = src[b++];
        end
        while (a < m) dst[k++] = src[a++];
        while (b < e) dst[k++] = src[b++];
      end
      src = dst;
    end
    for (int i = 0; i < n; i++) store_m[i] = src[i];
    head_m = 0;
  endtask

  task automatic predict(input logic [2:0] kind, input logic [31:0] value);
    dq_result_t r;
    r = '0;
    case (kind)
      KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
        if (count_m >= 16) r.status = STAT_FULL;
        else begin
          if (kind == KIND_PUSH_FRONT) begin
            head_m = head_m - 4'd1;
            store_m[head_m] = value;
          end else store_m[slot(count_m)] = value;
          count_m++;
        end
      end
      KIND_POP_FRONT, KIND_PEEK_FRONT, KIND_POP_BACK, KIND_PEEK_BACK: begin
        if (count_m == 0) r.status = STAT_EMPTY;
        else if (kind == KIND_POP_FRONT || kind == KIND_PEEK_FRONT) begin
          r.data = store_m[head_m];
          if (kind == KIND_POP_FRONT) begin
            head_m = head_m + 4'd1;
            count_m--;
          end
        end else begin
          r.data = store_m[slot(count_m - 1)];
          if (kind == KIND_POP_BACK) count_m--;
        end
      end
      KIND_SORT: sort_model();
      default: begin
        count_m = 0;
        head_m = 0;
      end
    endcase
    r.count = count_m;
    exp_m[exp_wr] = r;
    exp_wr = exp_wr + 4'd1;
    exp_cnt++;
  endtask

  always @(posedge clk) begin
    dq_result_t exp_r, got;
    if (!rst_n) begin
      head_m = 0; count_m = 0; desc_m = 0; fail_count = 0;
      exp_wr = 0; exp_rd = 0; exp_cnt = 0;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_SORT_DESC)
        desc_m = cfg_pwdata[0];
      if (out_tvalid && out_tready) begin
        got = out_tdata[38:0];
        if (exp_cnt == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected result word %h", got);
        end else begin
          exp_r = exp_m[exp_rd];
          exp_rd = exp_rd + 4'd1;
          exp_cnt--;
          if (got !== exp_r || out_tdata[39] !== 1'b0) begin
            fail_count++;
            if (fail_count <= 10)
              $display("mismatch: data %h/%h status %0d/%0d count %0d/%0d (exp/got)",
                       exp_r.data, got.data, exp_r.status, got.status,
                       exp_r.count, got.count);
          end
        end
      end
      if (in_tvalid && in_tready) predict(in_tuser, in_tdata);
    end
  end

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the deque with merge sort
// directed corner words, then random push/pop/sort traffic with gaps
// ----------------------------------------------------------------------------
module tb_top;
  import dqms_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // value [31:0]
  logic [2:0]  in_tuser = '0;   // kind [2:0]
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;       // data [31:0], status [33:32], count [38:34]
  logic        cfg_psel = 0, cfg_penable = 0, cfg_pwrite = 0;
  logic [1:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;
  int          fail_count, pending;
  int          idle_cycles;
  bit          sink_stall_on = 1;

  always #4 clk = ~clk;

  deque_with_merge_sort dut (.*);

  dqms_checker chk (.*);

  // watchdog: fails the run when handshakes and config accesses stop, with margin above a sort of 16 and long gaps
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_psel)
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 1) == 0) return 0;
    return $urandom_range(1, 3);
  endfunction

  // receiver with random stalls, drives at falling edge
  initial begin
    int g;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (!sink_stall_on) out_tready <= 1;
      else begin
        g = gap_len();
        if (g == 0) out_tready <= 1;
        else begin
          out_tready <= 0;
          repeat (g - 1) @(negedge clk);
        end
      end
    end
  end

  // ready is checked mid-cycle, the word goes at the next rising edge
  task automatic send_word(input logic [2:0] kind, input logic [31:0] value);
    @(negedge clk);
    in_tvalid <= 1;
    in_tuser  <= kind;
    in_tdata  <= value;
    while (!in_tready) @(negedge clk);
    @(posedge clk);
    @(negedge clk);
    in_tvalid <= 0;
  endtask

  task automatic send_gap(input logic [2:0] kind, input logic [31:0] value);
    int g;
    g = gap_len();
    repeat (g) @(negedge clk);
    send_word(kind, value);
  endtask

  task automatic cfg_write(input logic [31:0] val);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_paddr <= REG_SORT_DESC; cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1;
    @(negedge clk);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
  endtask

  task automatic drain();
    while (pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // random content biased toward small and near-maximum values so ties appear in sorts
  function automatic logic [31:0] rand_val();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 7);
      1: return 32'hFFFF_FFF8 | $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  initial begin
    int fill;
    logic [2:0] k;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    @(negedge clk);

    // directed: empty cases, extremes, full refusal, sort with ties
    cfg_write(32'h0);
    send_word(KIND_POP_FRONT, 0);
    send_word(KIND_POP_BACK, 0);
    send_word(KIND_PEEK_FRONT, 0);
    send_word(KIND_PEEK_BACK, 0);
    send_word(KIND_SORT, 0);
    send_word(KIND_PUSH_BACK, 32'hFFFF_FFFF);
    send_word(KIND_SORT, 0);
    send_word(KIND_PUSH_FRONT, 32'h0);
    send_word(KIND_PEEK_BACK, 0);
    for (int i = 0; i < 14; i++)
      send_word(i[0] ? KIND_PUSH_FRONT : KIND_PUSH_BACK, 32'(i % 3));
    send_word(KIND_PUSH_BACK, 32'h5555_AAAA);
    send_word(KIND_SORT, 0);
    send_word(KIND_PEEK_FRONT, 0);
    send_word(KIND_CLEAR, 0);

    // random phases, alternating sort direction
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      cfg_write(ph[0] ? 32'hFFFF_FFFF : 32'hFFFF_FFFE);
      if (ph == 3) sink_stall_on = 0;
      else sink_stall_on = 1;
      for (int n = 0; n < 175; ) begin
        if ($urandom_range(0, 9) < 8) begin
          // fill, sort, drain sequence
          fill = $urandom_range(1, 17);
          for (int j = 0; j < fill && n < 175; j++, n++)
            send_gap(3'($urandom_range(0, 1)), rand_val());
          send_gap(KIND_SORT, $urandom); n++;
          for (int j = 0; j < fill && n < 175; j++, n++) begin
            k = 3'($urandom_range(2, 5));
            send_gap(k, $urandom);
          end
        end else begin
          k = 3'($urandom_range(0, 7));
          send_gap(k, $urandom); n++;
        end
        if (n > 80 && n < 90) drain();
      end
    end
    drain();
    sink_stall_on = 0;
    repeat (20) @(negedge clk);

    if (fail_count == 0 && pending == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
